[sv/jfhs_pkg.sv]
// Package for the JPEG frame header scanner: parse phases, marker codes,
// status codes and the result record shared by the parser, output stage and top.
// No dependencies.
package jfhs_pkg;

  // Byte position counter width and its largest value
  localparam int unsigned POS_W = 32;
  localparam logic [63:0] POS_MAX = {64{1'b1}} >> (64 - POS_W);

  // Marker bytes
  localparam logic [7:0] MRK_PREFIX = 8'hFF;
  localparam logic [7:0] MRK_SOI    = 8'hD8;
  localparam logic [7:0] MRK_EOI    = 8'hD9;
  localparam logic [7:0] MRK_SOS    = 8'hDA;

  // Result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_NO_SOI    = 3'd2;
  localparam logic [2:0] ST_SCAN      = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;
  localparam logic [2:0] ST_SHORT_SOF = 3'd5;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd6;
  localparam logic [2:0] ST_END       = 3'd7;

  // Parse phases, one-hot
  typedef enum logic [12:0] {
    PH_IDLE   = 13'b0000000000001,
    PH_SOI1   = 13'b0000000000010,
    PH_HUNT   = 13'b0000000000100,
    PH_MARKER = 13'b0000000001000,
    PH_LEN_HI = 13'b0000000010000,
    PH_LEN_LO = 13'b0000000100000,
    PH_SKIP   = 13'b0000001000000,
    PH_PREC   = 13'b0000010000000,
    PH_H1     = 13'b0000100000000,
    PH_H0     = 13'b0001000000000,
    PH_W1     = 13'b0010000000000,
    PH_W0     = 13'b0100000000000,
    PH_NC     = 13'b1000000000000
  } phase_e;

  // One result item
  typedef struct packed {
    logic        found;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [7:0]  component_count;
    logic [2:0]  status;
  } result_t;

  // Start-of-frame marker set: C0-C3, C5-C7, C9-CB, CD-CF
  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hC) && (m[1:0] != 2'b00 || m[3:2] == 2'b00);
  endfunction

endpackage

[sv/jfhs_parser.sv]
// Byte-wise JPEG marker parser: phase register, position and length counters,
// frame field capture. Produces at most one result per accepted byte.
// Depends on jfhs_pkg.
module jfhs_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [7:0]        data_byte_i,
  input  logic              first_byte_i,
  input  logic [31:0]       file_length_i,
  output logic              res_valid_o,
  output jfhs_pkg::result_t res_o
);

  localparam int unsigned PW = jfhs_pkg::POS_W;

  jfhs_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]    pos_q, pos_d;
  logic [PW-1:0]    limit_q, limit_d;
  logic [7:0]       len_hi_q, len_hi_d;
  logic [15:0]      skip_q, skip_d;
  logic [7:0]       marker_q, marker_d;
  logic [15:0]      height_q, height_d;
  logic [15:0]      width_q, width_d;

  logic [63:0]      len_ext;
  logic [PW-1:0]    new_limit;
  logic [PW:0]      pos_p2;
  logic             hunt_stop;
  logic [15:0]      seg_size;
  logic [PW:0]      seg_end;
  logic [PW-1:0]    pos_p1;

  // Clip the sampled file length to the counter range
  assign len_ext   = 64'(file_length_i);
  assign new_limit = (len_ext > jfhs_pkg::POS_MAX) ? jfhs_pkg::POS_MAX[PW-1:0]
                                                   : len_ext[PW-1:0];

  // Shared position compares
  assign pos_p1    = pos_q + 1'b1;
  assign pos_p2    = {1'b0, pos_q} + (PW+1)'(2);
  assign hunt_stop = pos_p2 >= {1'b0, limit_q};
  assign seg_size  = {len_hi_q, data_byte_i};
  assign seg_end   = {1'b0, pos_q} - 1'b1 + (PW+1)'(seg_size);

  // Next-state and result logic
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    limit_d     = limit_q;
    len_hi_d    = len_hi_q;
    skip_d      = skip_q;
    marker_d    = marker_q;
    height_d    = height_q;
    width_d     = width_q;
    res_valid_o = 1'b0;
    res_o       = '0;

    if (first_byte_i) begin
      limit_d  = new_limit;
      pos_d    = '0;
      len_hi_d = '0;
      skip_d   = '0;
      marker_d = '0;
      height_d = '0;
      width_d  = '0;
      phase_d  = jfhs_pkg::PH_IDLE;
      if (new_limit < PW'(4)) begin
        res_valid_o = 1'b1;
        res_o.status = jfhs_pkg::ST_SHORT;
      end else if (data_byte_i != jfhs_pkg::MRK_PREFIX) begin
        res_valid_o = 1'b1;
        res_o.status = jfhs_pkg::ST_NO_SOI;
      end else begin
        phase_d = jfhs_pkg::PH_SOI1;
        pos_d   = PW'(1);
      end
    end else begin
      unique case (phase_q)
        jfhs_pkg::PH_IDLE: begin
        end
        jfhs_pkg::PH_SOI1: begin
          if (data_byte_i != jfhs_pkg::MRK_SOI) begin
            res_valid_o  = 1'b1;
            res_o.status = jfhs_pkg::ST_NO_SOI;
            phase_d      = jfhs_pkg::PH_IDLE;
          end else begin
            pos_d = pos_p1;
            if (hunt_stop) begin
              res_valid_o  = 1'b1;
              res_o.status = jfhs_pkg::ST_END;
              phase_d      = jfhs_pkg::PH_IDLE;
            end else begin
              phase_d = jfhs_pkg::PH_HUNT;
            end
          end
        end
        jfhs_pkg::PH_HUNT: begin
          pos_d = pos_p1;
          if (data_byte_i == jfhs_pkg::MRK_PREFIX) begin
            phase_d = jfhs_pkg::PH_MARKER;
          end else if (hunt_stop) begin
            res_valid_o  = 1'b1;
            res_o.status = jfhs_pkg::ST_END;
            phase_d      = jfhs_pkg::PH_IDLE;
          end
        end
        jfhs_pkg::PH_MARKER: begin
          if (data_byte_i == jfhs_pkg::MRK_SOI || data_byte_i == jfhs_pkg::MRK_EOI) begin
            // standalone marker: back to hunting
            pos_d = pos_p1;
            if (hunt_stop) begin
              res_valid_o  = 1'b1;
              res_o.status = jfhs_pkg::ST_END;
              phase_d      = jfhs_pkg::PH_IDLE;
            end else begin
              phase_d = jfhs_pkg::PH_HUNT;
            end
          end else if (data_byte_i == jfhs_pkg::MRK_SOS) begin
            res_valid_o  = 1'b1;
            res_o.status = jfhs_pkg::ST_SCAN;
            phase_d      = jfhs_pkg::PH_IDLE;
          end else if (hunt_stop) begin
            // no room for the length field
            res_valid_o  = 1'b1;
            res_o.status = jfhs_pkg::ST_BAD_LEN;
            phase_d      = jfhs_pkg::PH_IDLE;
          end else begin
            marker_d = data_byte_i;
            pos_d    = pos_p1;
            phase_d  = jfhs_pkg::PH_LEN_HI;
          end
        end
        jfhs_pkg::PH_LEN_HI: begin
          len_hi_d = data_byte_i;
          pos_d    = pos_p1;
          phase_d  = jfhs_pkg::PH_LEN_LO;
        end
        jfhs_pkg::PH_LEN_LO: begin
          if (seg_size < 16'd2 || seg_end > {1'b0, limit_q}) begin
            res_valid_o  = 1'b1;
            res_o.status = jfhs_pkg::ST_BAD_LEN;
            phase_d      = jfhs_pkg::PH_IDLE;
          end else begin
            pos_d = pos_p1;
            if (jfhs_pkg::is_sof(marker_q)) begin
              if (seg_size < 16'd8) begin
                res_valid_o  = 1'b1;
                res_o.status = jfhs_pkg::ST_SHORT_SOF;
                phase_d      = jfhs_pkg::PH_IDLE;
              end else begin
                phase_d = jfhs_pkg::PH_PREC;
              end
            end else if (seg_size == 16'd2) begin
              // empty segment
              if (hunt_stop) begin
                res_valid_o  = 1'b1;
                res_o.status = jfhs_pkg::ST_END;
                phase_d      = jfhs_pkg::PH_IDLE;
              end else begin
                phase_d = jfhs_pkg::PH_HUNT;
              end
            end else begin
              skip_d  = seg_size - 16'd2;
              phase_d = jfhs_pkg::PH_SKIP;
            end
          end
        end
        jfhs_pkg::PH_SKIP: begin
          skip_d = skip_q - 16'd1;
          pos_d  = pos_p1;
          if (skip_q == 16'd1) begin
            if (hunt_stop) begin
              res_valid_o  = 1'b1;
              res_o.status = jfhs_pkg::ST_END;
              phase_d      = jfhs_pkg::PH_IDLE;
            end else begin
              phase_d = jfhs_pkg::PH_HUNT;
            end
          end
        end
        jfhs_pkg::PH_PREC: begin
          pos_d   = pos_p1;
          phase_d = jfhs_pkg::PH_H1;
        end
        jfhs_pkg::PH_H1: begin
          height_d = {data_byte_i, 8'h00};
          pos_d    = pos_p1;
          phase_d  = jfhs_pkg::PH_H0;
        end
        jfhs_pkg::PH_H0: begin
          height_d = {height_q[15:8], data_byte_i};
          pos_d    = pos_p1;
          phase_d  = jfhs_pkg::PH_W1;
        end
        jfhs_pkg::PH_W1: begin
          width_d = {data_byte_i, 8'h00};
          pos_d   = pos_p1;
          phase_d = jfhs_pkg::PH_W0;
        end
        jfhs_pkg::PH_W0: begin
          width_d = {width_q[15:8], data_byte_i};
          pos_d   = pos_p1;
          phase_d = jfhs_pkg::PH_NC;
        end
        jfhs_pkg::PH_NC: begin
          pos_d                 = pos_p1;
          phase_d               = jfhs_pkg::PH_IDLE;
          res_valid_o           = 1'b1;
          res_o.image_width     = width_q;
          res_o.image_height    = height_q;
          res_o.component_count = data_byte_i;
          if (width_q == 16'd0 || height_q == 16'd0) begin
            res_o.status = jfhs_pkg::ST_ZERO_SIZE;
          end else begin
            res_o.status = jfhs_pkg::ST_OK;
            res_o.found  = 1'b1;
          end
        end
        default: begin
          phase_d = jfhs_pkg::PH_IDLE;
        end
      endcase
    end
  end

  // State registers, updated on each input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= jfhs_pkg::PH_IDLE;
      pos_q    <= '0;
      limit_q  <= '0;
      len_hi_q <= '0;
      skip_q   <= '0;
      marker_q <= '0;
      height_q <= '0;
      width_q  <= '0;
    end else if (accept_i) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      limit_q  <= limit_d;
      len_hi_q <= len_hi_d;
      skip_q   <= skip_d;
      marker_q <= marker_d;
      height_q <= height_d;
      width_q  <= width_d;
    end
  end

  // Checks
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.found == (res_o.status == jfhs_pkg::ST_OK)))
    else $error("found disagrees with status");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && res_valid_o) |=> (phase_q == jfhs_pkg::PH_IDLE))
    else $error("parser not idle after a result");

  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == jfhs_pkg::PH_IDLE && !first_byte_i) |-> !res_valid_o)
    else $error("result produced while idle");

  a_skip_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == jfhs_pkg::PH_SKIP) |-> (skip_q != 16'd0))
    else $error("skip count empty in skip phase");

endmodule

[sv/jfhs_out_reg.sv]
// Result register for the scanner: holds one result until the downstream
// transfer, and lets a new byte in while the held result is being taken.
// Depends on jfhs_pkg.
module jfhs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  jfhs_pkg::result_t res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output jfhs_pkg::result_t res_o
);

  logic              valid_q;
  jfhs_pkg::result_t res_q;

  // Slot is free when empty or draining this cycle
  assign free_o      = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

[sv/jpeg_frame_header_scanner.sv]
// JPEG frame header scanner: one file byte per transfer, at most one result per file.
// Throughput: one byte per cycle, except while a held result waits downstream.
// Latency: a result is presented in the cycle after the byte that ends the parse.
// Input ready drops only while a held result is not taken downstream.
// Reset (rst_ni low, asynchronous) returns the parser to idle and empties
// the result register. Depends on jfhs_pkg, jfhs_parser, jfhs_out_reg.
module jpeg_frame_header_scanner (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [31:0] file_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        found_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [7:0]  component_count_o,
  output logic [2:0]  status_o
);

  logic              accept;
  logic              res_valid;
  logic              slot_free;
  jfhs_pkg::result_t res_new;
  jfhs_pkg::result_t res_out;

  assign in_ready_o = slot_free;
  assign accept     = in_valid_i && slot_free;

  jfhs_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .file_length_i(file_length_i),
    .res_valid_o  (res_valid),
    .res_o        (res_new)
  );

  jfhs_out_reg u_out_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept && res_valid),
    .res_i      (res_new),
    .free_o     (slot_free),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .res_o      (res_out)
  );

  // Result fields
  assign found_o           = res_out.found;
  assign image_width_o     = res_out.image_width;
  assign image_height_o    = res_out.image_height;
  assign component_count_o = res_out.component_count;
  assign status_o          = res_out.status;

endmodule

[dv/jpeg_frame_header_scanner_tb.sv]
// Self-checking testbench for jpeg_frame_header_scanner: streams JPEG-like files
// byte by byte and checks each frame header result against a built-in parser model.
// Depends on jfhs_pkg and the jpeg_frame_header_scanner RTL.
module jpeg_frame_header_scanner_tb;

  // Marker bytes not held in the package
  localparam logic [7:0] MRK_SOF0  = 8'hC0;
  localparam logic [7:0] MRK_SOF1  = 8'hC1;
  localparam logic [7:0] MRK_SOF2  = 8'hC2;
  localparam logic [7:0] MRK_SOF3  = 8'hC3;
  localparam logic [7:0] MRK_DHT   = 8'hC4;
  localparam logic [7:0] MRK_JPG   = 8'hC8;
  localparam logic [7:0] MRK_DAC   = 8'hCC;
  localparam logic [7:0] MRK_SOF15 = 8'hCF;
  localparam logic [7:0] MRK_APP0  = 8'hE0;
  localparam logic [7:0] MRK_APP1  = 8'hE1;
  localparam logic [7:0] MRK_COM   = 8'hFE;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        first_byte_i;
  logic [31:0] file_length_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        found_o;
  logic [15:0] image_width_o;
  logic [15:0] image_height_o;
  logic [7:0]  component_count_o;
  logic [2:0]  status_o;

  jpeg_frame_header_scanner u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .data_byte_i       (data_byte_i),
    .first_byte_i      (first_byte_i),
    .file_length_i     (file_length_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .found_o           (found_o),
    .image_width_o     (image_width_o),
    .image_height_o    (image_height_o),
    .component_count_o (component_count_o),
    .status_o          (status_o)
  );

  // Parser model plus the queue of frame headers still owed by the block
  class frame_scoreboard;
    jfhs_pkg::phase_e  phase;
    logic [63:0]       pos;
    logic [63:0]       limit;
    logic [15:0]       seg_size;
    logic [15:0]       skip_left;
    logic [7:0]        marker;
    logic [15:0]       height;
    logic [15:0]       width;
    jfhs_pkg::result_t pending_headers[$];
    int unsigned       fail_count;
    int unsigned       results_seen;
    int unsigned       frames_found;

    function new();
      clear_state();
      fail_count   = 0;
      results_seen = 0;
      frames_found = 0;
    endfunction

    function void clear_state();
      phase     = jfhs_pkg::PH_IDLE;
      pos       = '0;
      limit     = '0;
      seg_size  = '0;
      skip_left = '0;
      marker    = '0;
      height    = '0;
      width     = '0;
    endfunction

    // C0-CF except DHT, JPG and DAC
    static function logic is_frame_marker(logic [7:0] m);
      return m >= MRK_SOF0 && m <= MRK_SOF15 && m != MRK_DHT && m != MRK_JPG && m != MRK_DAC;
    endfunction

    function void close_file(logic [2:0] st, logic [15:0] w, logic [15:0] h, logic [7:0] nc);
      jfhs_pkg::result_t r;
      r.found           = (st == jfhs_pkg::ST_OK);
      r.image_width     = w;
      r.image_height    = h;
      r.component_count = nc;
      r.status          = st;
      pending_headers   = {pending_headers, r};
      phase = jfhs_pkg::PH_IDLE;
    endfunction

    // Hunting needs a byte and one after it before the end of file
    function void resume_hunt(logic [63:0] next);
      pos = next;
      if (next + 1 >= limit) close_file(jfhs_pkg::ST_END, '0, '0, '0);
      else phase = jfhs_pkg::PH_HUNT;
    endfunction

    // Advance the model by one transferred byte
    function void note_byte(logic [7:0] b, logic fb, logic [31:0] flen);
      logic [63:0] p;
      if (fb) begin
        clear_state();
        limit = {32'd0, flen};
        if (limit > jfhs_pkg::POS_MAX) limit = jfhs_pkg::POS_MAX;
        if (limit < 4) close_file(jfhs_pkg::ST_SHORT, '0, '0, '0);
        else if (b != jfhs_pkg::MRK_PREFIX) close_file(jfhs_pkg::ST_NO_SOI, '0, '0, '0);
        else begin
          phase = jfhs_pkg::PH_SOI1;
          pos   = 1;
        end
        return;
      end
      p = pos;
      case (phase)
        jfhs_pkg::PH_SOI1: begin
          if (b != jfhs_pkg::MRK_SOI) close_file(jfhs_pkg::ST_NO_SOI, '0, '0, '0);
          else resume_hunt(2);
        end
        jfhs_pkg::PH_HUNT: begin
          if (b == jfhs_pkg::MRK_PREFIX) begin
            phase = jfhs_pkg::PH_MARKER;
            pos   = p + 1;
          end else begin
            resume_hunt(p + 1);
          end
        end
        jfhs_pkg::PH_MARKER: begin
          if (b == jfhs_pkg::MRK_SOI || b == jfhs_pkg::MRK_EOI) resume_hunt(p + 1);
          else if (b == jfhs_pkg::MRK_SOS) close_file(jfhs_pkg::ST_SCAN, '0, '0, '0);
          else if (p + 2 >= limit) close_file(jfhs_pkg::ST_BAD_LEN, '0, '0, '0);
          else begin
            marker = b;
            phase  = jfhs_pkg::PH_LEN_HI;
            pos    = p + 1;
          end
        end
        jfhs_pkg::PH_LEN_HI: begin
          seg_size = {b, 8'h00};
          phase    = jfhs_pkg::PH_LEN_LO;
          pos      = p + 1;
        end
        jfhs_pkg::PH_LEN_LO: begin
          seg_size[7:0] = b;
          if (seg_size < 2 || (p - 1) + {48'd0, seg_size} > limit) begin
            close_file(jfhs_pkg::ST_BAD_LEN, '0, '0, '0);
          end else begin
            pos = p + 1;
            if (is_frame_marker(marker)) begin
              if (seg_size < 8) close_file(jfhs_pkg::ST_SHORT_SOF, '0, '0, '0);
              else phase = jfhs_pkg::PH_PREC;
            end else if (seg_size == 2) begin
              resume_hunt(p + 1);
            end else begin
              skip_left = seg_size - 16'd2;
              phase     = jfhs_pkg::PH_SKIP;
            end
          end
        end
        jfhs_pkg::PH_SKIP: begin
          skip_left = skip_left - 16'd1;
          if (skip_left == 0) resume_hunt(p + 1);
          else pos = p + 1;
        end
        jfhs_pkg::PH_PREC: begin
          phase = jfhs_pkg::PH_H1;
          pos   = p + 1;
        end
        jfhs_pkg::PH_H1: begin
          height = {b, 8'h00};
          phase  = jfhs_pkg::PH_H0;
          pos    = p + 1;
        end
        jfhs_pkg::PH_H0: begin
          height[7:0] = b;
          phase       = jfhs_pkg::PH_W1;
          pos         = p + 1;
        end
        jfhs_pkg::PH_W1: begin
          width = {b, 8'h00};
          phase = jfhs_pkg::PH_W0;
          pos   = p + 1;
        end
        jfhs_pkg::PH_W0: begin
          width[7:0] = b;
          phase      = jfhs_pkg::PH_NC;
          pos        = p + 1;
        end
        jfhs_pkg::PH_NC: begin
          pos = p + 1;
          if (width == 0 || height == 0)
            close_file(jfhs_pkg::ST_ZERO_SIZE, width, height, b);
          else
            close_file(jfhs_pkg::ST_OK, width, height, b);
        end
        default: ;
      endcase
    endfunction

    task report(string what);
      $display("[%0t] MISMATCH: %s", $realtime, what);
      fail_count++;
    endtask

    // Compare one transferred result with the oldest outstanding header
    task check_result(jfhs_pkg::result_t got);
      jfhs_pkg::result_t want;
      results_seen++;
      if (got.found) frames_found++;
      if (pending_headers.size() == 0) begin
        report($sformatf("unexpected result, status %0d", got.status));
        return;
      end
      want = pending_headers.pop_front();
      if (got.found != want.found)
        report($sformatf("found %0b, want %0b", got.found, want.found));
      if (got.image_width != want.image_width)
        report($sformatf("width %h, want %h", got.image_width, want.image_width));
      if (got.image_height != want.image_height)
        report($sformatf("height %h, want %h", got.image_height, want.image_height));
      if (got.component_count != want.component_count)
        report($sformatf("components %h, want %h", got.component_count,
                         want.component_count));
      if (got.status != want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  frame_scoreboard sb;
  logic [7:0]      file_bytes[$];
  logic [31:0]     file_len;
  int unsigned     bytes_sent;
  int unsigned     files_sent;
  int unsigned     burst_left;
  int unsigned     rcv_cycle;
  int unsigned     stall_left;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One byte transfer; bursts of random length separated by random gaps
  task automatic send_byte(input logic [7:0] b, input logic fb, input logic [31:0] flen);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    data_byte_i   <= b;
    first_byte_i  <= fb;
    file_length_i <= flen;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_byte(b, fb, flen);
    burst_left--;
    bytes_sent++;
  endtask

  // Whole file; length is only meaningful on byte 0, the rest carry noise
  task automatic send_file(input logic [31:0] flen);
    foreach (file_bytes[i])
      send_byte(file_bytes[i], i == 0, (i == 0) ? flen : 32'($urandom()));
    files_sent++;
  endtask

  // Append one byte to the file under construction
  task automatic add_byte(input logic [7:0] b);
    file_bytes = {file_bytes, b};
  endtask

  function automatic logic [7:0] filler_byte();
    logic [7:0] v;
    v = 8'($urandom());
    if (v == jfhs_pkg::MRK_PREFIX) v = 8'h00;
    return v;
  endfunction

  function automatic logic [15:0] random_extent();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 16'hFFFF));
    endcase
  endfunction

  task automatic add_segment(input logic [7:0] m);
    logic [15:0] seg_len;
    seg_len = ($urandom_range(0, 24) == 0) ? 16'($urandom_range(256, 280))
                                           : 16'($urandom_range(2, 8));
    add_byte(jfhs_pkg::MRK_PREFIX);
    add_byte(m);
    add_byte(seg_len[15:8]);
    add_byte(seg_len[7:0]);
    repeat (seg_len - 2) add_byte(8'($urandom()));
  endtask

  // Mostly well-formed file: SOI, up to four segments, filler runs or standalone markers, then SOF, SOS or nothing
  task automatic make_random_file();
    logic [7:0]  m;
    logic [15:0] h;
    logic [15:0] w;
    int unsigned sof_len;
    int unsigned sz;
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI};
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 7))
        0: repeat ($urandom_range(1, 3)) add_byte(filler_byte());
        1: begin
          add_byte(jfhs_pkg::MRK_PREFIX);
          add_byte($urandom_range(0, 1) ? jfhs_pkg::MRK_SOI : jfhs_pkg::MRK_EOI);
        end
        2: add_segment(jfhs_pkg::MRK_PREFIX);
        3: add_segment(MRK_DHT);
        default: add_segment(MRK_APP0 + 8'($urandom_range(0, 15)));
      endcase
    end
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        do m = MRK_SOF0 + 8'($urandom_range(0, 15));
        while (!frame_scoreboard::is_frame_marker(m));
        sof_len = $urandom_range(8, 10);
        h = random_extent();
        w = random_extent();
        add_byte(jfhs_pkg::MRK_PREFIX);
        add_byte(m);
        add_byte(8'h00);
        add_byte(8'(sof_len));
        add_byte(8'd8);
        add_byte(h[15:8]);
        add_byte(h[7:0]);
        add_byte(w[15:8]);
        add_byte(w[7:0]);
        add_byte(8'($urandom()));
        repeat (sof_len - 8) add_byte(8'($urandom()));
      end
      6, 7: begin
        add_byte(jfhs_pkg::MRK_PREFIX);
        add_byte(jfhs_pkg::MRK_SOS);
        add_byte(8'h00);
        add_byte(8'h0C);
      end
      default: ;
    endcase
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom()));
    sz = file_bytes.size();
    case ($urandom_range(0, 15))
      0: file_len = $urandom_range(0, sz);
      1: file_len = sz + $urandom_range(1, 4);
      2: file_len = $urandom();
      default: file_len = sz;
    endcase
    // Occasionally break the stream with one corrupted byte
    if ($urandom_range(0, 5) == 0)
      file_bytes[$urandom_range(0, sz - 1)] = 8'($urandom());
  endtask

  // Receiver: cycles through always ready, random, sparse and long-stall modes
  initial begin
    out_ready_i = 1'b0;
    rcv_cycle   = 0;
    stall_left  = 0;
    forever begin
      @(negedge clk_i);
      rcv_cycle++;
      case (rcv_cycle[8:7])
        2'd0: out_ready_i <= 1'b1;
        2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
        2'd2: out_ready_i <= (rcv_cycle[2:0] == 3'd0);
        default: begin
          if (stall_left > 0) begin
            stall_left--;
            out_ready_i <= 1'b0;
          end else begin
            out_ready_i <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
          end
        end
      endcase
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result(jfhs_pkg::result_t'({found_o, image_width_o, image_height_o,
                                           component_count_o, status_o}));
  end

  // Watchdog
  initial begin
    #4000000;
    $display("Timeout: results still outstanding or input stuck");
    $display("Verification failed");
    $finish;
  end

  // Stimulus
  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    first_byte_i  = 1'b0;
    file_length_i = 32'd0;
    bytes_sent    = 0;
    files_sent    = 0;
    burst_left    = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Stray bytes while idle are ignored
    send_byte(8'hFF, 1'b0, 32'hFFFF_FFFF);
    send_byte(jfhs_pkg::MRK_SOI, 1'b0, 32'd0);
    // Short file
    file_bytes = {jfhs_pkg::MRK_PREFIX};
    send_file(32'd3);
    // Missing SOI on byte 0, then on byte 1
    file_bytes = {jfhs_pkg::MRK_SOI};
    send_file(32'd4);
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_EOI};
    send_file(32'd4);
    // Hunt runs into the end of file
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, 8'h00, 8'h00};
    send_file(32'd4);
    // Standalone EOI passed over, then start of scan
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX,
                  jfhs_pkg::MRK_EOI, jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOS};
    send_file(32'd100);
    // Marker with no room for a length
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_APP1};
    send_file(32'd5);
    // Length below two, then length past the end
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_APP1,
                  8'h00, 8'h01};
    send_file(32'd16);
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_APP1,
                  8'h00, 8'h08};
    send_file(32'd8);
    // Skip ending exactly at the end of file
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_APP0,
                  8'h00, 8'h04, 8'hAA, 8'hBB};
    send_file(32'd8);
    // Frame header too short
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_SOF3,
                  8'h00, 8'h07};
    send_file(32'd64);
    // Largest length, standalone SOI, 0xFF as a marker, empty segment, all-ones frame
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX,
                  jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_PREFIX,
                  8'h00, 8'h03, 8'h55, jfhs_pkg::MRK_PREFIX, MRK_COM, 8'h00, 8'h02,
                  jfhs_pkg::MRK_PREFIX, MRK_SOF15, 8'h00, 8'h08, 8'h08,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_file(32'hFFFF_FFFF);
    // File cut short by a new first byte, then a frame length past the end of file
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_SOF1,
                  8'h00};
    send_file(32'd40);
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_SOF0,
                  8'h00, 8'h0B, 8'h08, 8'h00, 8'h00, 8'h01, 8'h00, 8'h03};
    send_file(32'd12);
    // Zero width
    file_bytes = {jfhs_pkg::MRK_PREFIX, jfhs_pkg::MRK_SOI, jfhs_pkg::MRK_PREFIX, MRK_SOF2,
                  8'h00, 8'h08, 8'h08, 8'h12, 8'h34, 8'h00, 8'h00, 8'h01};
    send_file(32'd12);

    // Random files until enough bytes have gone through
    while (bytes_sent < 900) begin
      make_random_file();
      send_file(file_len);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_headers.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d files in %0d byte transfers; %0d results checked, %0d with a frame size",
             files_sent, bytes_sent, sb.results_seen, sb.frames_found);
    if (sb.fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
